[rtl/core/wams_pkg.sv]
package wams_pkg;

  localparam int CNT_W   = 13;
  localparam int CLS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CLS_W-1:0] CLS_EMPTY = 2'd0;
  localparam logic [CLS_W-1:0] CLS_TREE  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_ROCK  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_SIZE       = 3'd0,
    CFG_BORDER_WIDTH   = 3'd1,
    CFG_CENTER_SIZE    = 3'd2,
    CFG_PARK_SIZE      = 3'd3,
    CFG_ROCK_THRESHOLD = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]       map_size;
    logic [5:0]       border_width;
    logic [6:0]       center_size;
    logic [6:0]       park_size;
    logic [CNT_W-1:0] rock_threshold;
  } cfg_t;

  localparam logic [6:0]       RST_MAP_SIZE       = 7'd64;
  localparam logic [5:0]       RST_BORDER_WIDTH   = 6'd0;
  localparam logic [6:0]       RST_CENTER_SIZE    = 7'd1;
  localparam logic [6:0]       RST_PARK_SIZE      = 7'd1;
  localparam logic [CNT_W-1:0] RST_ROCK_THRESHOLD = 13'd0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } state_e;

endpackage

[rtl/core/wams_ram.sv]
module wams_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/wams_loader.sv]
module wams_loader
  import wams_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  load_i,
  input  logic                                  last_i,
  input  logic [CLS_W-1:0]                      cls_i,
  input  logic [CNT_W-1:0]                      tree_rdata_i,
  input  logic [CNT_W-1:0]                      rock_rdata_i,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  raddr_o,
  output logic                                  we_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  waddr_o,
  output logic [CNT_W-1:0]                      tree_wdata_o,
  output logic [CNT_W-1:0]                      rock_wdata_o
);

  localparam int PW = $clog2(MAX_SIDE);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int EW = ((PW > 7) ? PW : 7) + 2;

  logic [PW-1:0]    row_q, row_d, col_q, col_d;
  logic [CNT_W-1:0] left_tree_q, left_tree_d, left_rock_q, left_rock_d;
  logic [CNT_W-1:0] diag_tree_q, diag_tree_d, diag_rock_q, diag_rock_d;
  logic [EW-1:0]    map_ext, n_ext, col_inc, row_inc;
  logic             has_up, has_left;
  logic [CNT_W-1:0] tree_sum, rock_sum;

  always_comb begin
    map_ext = EW'(cfg_i.map_size);
    if (map_ext == '0) begin
      n_ext = EW'(1);
    end else if (map_ext > EW'(MAX_SIDE)) begin
      n_ext = EW'(MAX_SIDE);
    end else begin
      n_ext = map_ext;
    end
  end

  assign has_up   = (row_q != '0);
  assign has_left = (col_q != '0);

  // the cell above is fetched while waiting for the request
  assign raddr_o = has_up ? (AW'(row_q - PW'(1)) * AW'(MAX_SIDE) + AW'(col_q)) : '0;
  assign waddr_o = AW'(row_q) * AW'(MAX_SIDE) + AW'(col_q);
  assign we_o    = load_i;

  // left neighbour is the entry written last, diagonal is the previous upper read
  assign tree_sum = CNT_W'(cls_i == CLS_TREE)
                  + (has_up ? tree_rdata_i : '0)
                  + (has_left ? left_tree_q : '0)
                  - ((has_up && has_left) ? diag_tree_q : '0);
  assign rock_sum = CNT_W'(cls_i == CLS_ROCK)
                  + (has_up ? rock_rdata_i : '0)
                  + (has_left ? left_rock_q : '0)
                  - ((has_up && has_left) ? diag_rock_q : '0);

  assign tree_wdata_o = tree_sum;
  assign rock_wdata_o = rock_sum;

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    left_tree_d = left_tree_q;
    left_rock_d = left_rock_q;
    diag_tree_d = diag_tree_q;
    diag_rock_d = diag_rock_q;
    col_inc     = EW'(col_q) + EW'(1);
    row_inc     = EW'(row_q) + EW'(1);
    if (load_i) begin
      left_tree_d = tree_sum;
      left_rock_d = rock_sum;
      diag_tree_d = tree_rdata_i;
      diag_rock_d = rock_rdata_i;
      if (last_i) begin
        row_d = '0;
        col_d = '0;
      end else if (col_inc >= n_ext) begin
        col_d = '0;
        row_d = (row_inc >= n_ext) ? '0 : row_inc[PW-1:0];
      end else begin
        col_d = col_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_tree_q <= left_tree_d;
    left_rock_q <= left_rock_d;
    diag_tree_q <= diag_tree_d;
    diag_rock_q <= diag_rock_d;
  end

endmodule

[rtl/core/wams_scanner.sv]
module wams_scanner
  import wams_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  start_i,
  input  logic [CNT_W-1:0]                      tree_rdata_i,
  input  logic [CNT_W-1:0]                      rock_rdata_i,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  tree_raddr_o,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  rock_raddr_o,
  output logic                                  done_o,
  output logic [CNT_W-1:0]                      best_o
);

  localparam int PW = $clog2(MAX_SIDE);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int EW = ((PW > 7) ? PW : 7) + 2;

  // corners of a box sum, in the order they are fetched
  localparam logic [1:0] CRN_BR = 2'd0;
  localparam logic [1:0] CRN_TR = 2'd1;
  localparam logic [1:0] CRN_BL = 2'd2;
  localparam logic [1:0] CRN_TL = 2'd3;
  localparam logic [2:0] PH_EVAL = 3'd4;

  logic [PW-1:0]    row_q, row_d, col_q, col_d;
  logic [2:0]       phase_q, phase_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] acc_rock_q, acc_rock_d, acc_tree_q, acc_tree_d;
  logic [CNT_W-1:0] best_q, best_d;

  logic [EW-1:0]    map_ext, n_ext, l_ext, c_ext, k_ext, rr, cc;
  logic [EW-1:0]    rk_r1, rk_c1, tr_r0, tr_c0, tr_r1, tr_c1, nxt_col, nxt_row;
  logic             park_ok, empty_scan;
  logic [1:0]       data_corner;
  logic [CNT_W-1:0] rock_term, tree_term, rocks_total, trees_total;

  function automatic logic [AW-1:0] corner_addr(input logic [EW-1:0] r0,
                                                input logic [EW-1:0] c0,
                                                input logic [EW-1:0] r1,
                                                input logic [EW-1:0] c1,
                                                input logic [1:0]    corner,
                                                input logic          ok);
    logic [EW-1:0] r, c;
    r = ((corner == CRN_TR) || (corner == CRN_TL))
        ? ((r0 != '0) ? r0 - EW'(1) : '0) : r1;
    c = ((corner == CRN_BL) || (corner == CRN_TL))
        ? ((c0 != '0) ? c0 - EW'(1) : '0) : c1;
    if (!ok) begin
      r = '0;
      c = '0;
    end
    return AW'(r[PW-1:0]) * AW'(MAX_SIDE) + AW'(c[PW-1:0]);
  endfunction

  function automatic logic [CNT_W-1:0] corner_term(input logic [CNT_W-1:0] rd,
                                                   input logic [1:0]       corner,
                                                   input logic             top_ok,
                                                   input logic             left_ok);
    logic [CNT_W-1:0] t;
    t = '0;
    case (corner)
      CRN_BR:  t = rd;
      CRN_TR:  t = top_ok ? -rd : '0;
      CRN_BL:  t = left_ok ? -rd : '0;
      CRN_TL:  t = (top_ok && left_ok) ? rd : '0;
      default: t = '0;
    endcase
    return t;
  endfunction

  always_comb begin
    map_ext = EW'(cfg_i.map_size);
    if (map_ext == '0) begin
      n_ext = EW'(1);
    end else if (map_ext > EW'(MAX_SIDE)) begin
      n_ext = EW'(MAX_SIDE);
    end else begin
      n_ext = map_ext;
    end
    l_ext = EW'(cfg_i.border_width);
    c_ext = (cfg_i.center_size == '0) ? EW'(1) : EW'(cfg_i.center_size);
    k_ext = (cfg_i.park_size == '0) ? EW'(1) : EW'(cfg_i.park_size);
  end

  assign rr    = EW'(row_q);
  assign cc    = EW'(col_q);
  assign rk_r1 = rr + c_ext - EW'(1);
  assign rk_c1 = cc + c_ext - EW'(1);
  assign tr_r0 = rr - l_ext;
  assign tr_c0 = cc - l_ext;
  assign tr_r1 = tr_r0 + k_ext - EW'(1);
  assign tr_c1 = tr_c0 + k_ext - EW'(1);

  // park must fit inside the map
  assign park_ok    = ((tr_r0 + k_ext) <= n_ext) && ((tr_c0 + k_ext) <= n_ext);
  assign empty_scan = (l_ext + l_ext + c_ext) > n_ext;

  assign rock_raddr_o = corner_addr(rr, cc, rk_r1, rk_c1, phase_q[1:0], 1'b1);
  assign tree_raddr_o = corner_addr(tr_r0, tr_c0, tr_r1, tr_c1, phase_q[1:0], park_ok);

  // read data lags the address by one phase
  assign data_corner = phase_q[1:0] - 2'd1;
  assign rock_term   = corner_term(rock_rdata_i, data_corner, rr != '0, cc != '0);
  assign tree_term   = corner_term(tree_rdata_i, data_corner, tr_r0 != '0, tr_c0 != '0);
  assign rocks_total = acc_rock_q + rock_term;
  assign trees_total = acc_tree_q + tree_term;

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    phase_d    = phase_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    acc_rock_d = acc_rock_q;
    acc_tree_d = acc_tree_q;
    best_d     = best_q;
    nxt_col    = cc + EW'(1);
    nxt_row    = rr + EW'(1);
    if (start_i) begin
      best_d  = '0;
      row_d   = l_ext[PW-1:0];
      col_d   = l_ext[PW-1:0];
      phase_d = '0;
      if (empty_scan) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (phase_q == PH_EVAL) begin
        if (park_ok && (rocks_total >= cfg_i.rock_threshold) && (trees_total > best_q)) begin
          best_d = trees_total;
        end
        phase_d = '0;
        if ((nxt_col + c_ext + l_ext) > n_ext) begin
          col_d = l_ext[PW-1:0];
          if ((nxt_row + c_ext + l_ext) > n_ext) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            row_d = nxt_row[PW-1:0];
          end
        end else begin
          col_d = nxt_col[PW-1:0];
        end
      end else begin
        phase_d = phase_q + 3'd1;
        if (phase_q == 3'd1) begin
          acc_rock_d = rock_term;
          acc_tree_d = tree_term;
        end else if (phase_q != '0) begin
          acc_rock_d = rocks_total;
          acc_tree_d = trees_total;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    acc_rock_q <= acc_rock_d;
    acc_tree_q <= acc_tree_d;
    best_q     <= best_d;
  end

  assign done_o = done_q;
  assign best_o = best_q;

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && $past(busy_q)) |-> (best_q >= $past(best_q)))
    else $error("best count dropped during a scan");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("scan reports done while still running");

endmodule

[rtl/core/windowed_area_max_search.sv]
// Windowed area maximum search.
// Cells of a square map arrive on the input channel (in_valid_i / in_stall_o) in
// row-major order, one request per cell; each cell is handled by first fetching the
// prefix entry above it and then writing both prefix sums, and in_stall_o is high
// while a cell is written, so no new cell is taken before that. The cell flagged
// by last_cell_i starts the window scan, with P = (n - 2l - c + 1)^2 candidate center
// positions; each takes four reads of each prefix memory plus an evaluation step,
// done one after another since each prefix memory has a single read port.
// One result request per map leaves on out_valid_o / out_stall_i from an output
// register; more cells are taken while it waits, but a second result waits in
// ST_DONE, taking no cells, until the first one is taken. Configuration writes
// (cfg_valid_i, always ready) must only happen while the block is idle.
// Reset sets state and configuration to defaults and the load position to the top
// left; the prefix memories are not cleared and every cell of a map must be sent.
module windowed_area_max_search
  import wams_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CLS_W-1:0]      cell_class_i,
  input  logic                  last_cell_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CNT_W-1:0]      best_tree_count_o
);

  localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  state_e state_q, state_d;
  cfg_t   cfg_q, cfg_d;

  logic [CLS_W-1:0] cls_q, cls_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_data_q, out_data_d;

  logic             in_accept, out_free, scan_start, scan_done, ld_we, ld_active;
  logic [AW-1:0]    ld_raddr, ld_waddr, sc_tree_raddr, sc_rock_raddr;
  logic [AW-1:0]    tree_raddr, rock_raddr;
  logic [CNT_W-1:0] tree_wdata, rock_wdata, tree_rdata, rock_rdata, scan_best;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign ld_active   = (state_q == ST_LOAD);
  assign scan_start  = ld_active && last_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_SIZE:       cfg_d.map_size       = cfg_data_i[6:0];
        CFG_BORDER_WIDTH:   cfg_d.border_width   = cfg_data_i[5:0];
        CFG_CENTER_SIZE:    cfg_d.center_size    = cfg_data_i[6:0];
        CFG_PARK_SIZE:      cfg_d.park_size      = cfg_data_i[6:0];
        CFG_ROCK_THRESHOLD: cfg_d.rock_threshold = cfg_data_i[CNT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = (state_q != ST_IDLE);
    cls_d       = cls_q;
    last_d      = last_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cls_d   = cell_class_i;
          last_d  = last_cell_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = last_q ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = scan_best;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cfg_q       <= '{map_size:       RST_MAP_SIZE,
                       border_width:   RST_BORDER_WIDTH,
                       center_size:    RST_CENTER_SIZE,
                       park_size:      RST_PARK_SIZE,
                       rock_threshold: RST_ROCK_THRESHOLD};
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q      <= cls_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o       = out_valid_q;
  assign best_tree_count_o = out_data_q;

  // scan owns the read ports only while it runs
  assign tree_raddr = (state_q == ST_SCAN) ? sc_tree_raddr : ld_raddr;
  assign rock_raddr = (state_q == ST_SCAN) ? sc_rock_raddr : ld_raddr;

  wams_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (tree_wdata),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  wams_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_rock_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (rock_wdata),
    .raddr_i (rock_raddr),
    .rdata_o (rock_rdata)
  );

  wams_loader #(
    .MAX_SIDE (MAX_SIDE)
  ) u_loader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .load_i       (ld_active),
    .last_i       (last_q),
    .cls_i        (cls_q),
    .tree_rdata_i (tree_rdata),
    .rock_rdata_i (rock_rdata),
    .raddr_o      (ld_raddr),
    .we_o         (ld_we),
    .waddr_o      (ld_waddr),
    .tree_wdata_o (tree_wdata),
    .rock_wdata_o (rock_wdata)
  );

  wams_scanner #(
    .MAX_SIDE (MAX_SIDE)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (scan_start),
    .tree_rdata_i (tree_rdata),
    .rock_rdata_i (rock_rdata),
    .tree_raddr_o (sc_tree_raddr),
    .rock_raddr_o (sc_rock_raddr),
    .done_o       (scan_done),
    .best_o       (scan_best)
  );

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_LOAD))
    else $error("accepted cell not written to the prefix memories");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == ST_SCAN))
    else $error("scan finished outside the scan state");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=>
      (out_valid_o && (best_tree_count_o == $past(scan_best))))
    else $error("scan result not moved to the output register");

endmodule
